/* hdl/haptic_pattern_sequencer_unit_macros.svh */
// Assertion macros for the haptic pattern sequencer.
// Used by the checker module; no other dependencies.
`ifndef HAPTIC_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define HAPTIC_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define HPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/hps_pkg.sv */
// Types, pattern tables and constants of the haptic pattern sequencer.
// No dependencies.
`timescale 1ns / 1ps

package hps_pkg;

    localparam int NUM_PATTERNS = 7;
    localparam int MAX_STEPS    = 5;

    typedef logic [2:0] pattern_t;
    typedef logic [2:0] step_t;
    typedef logic [7:0] ms_t;
    typedef logic [7:0] duty_t;
    typedef logic [6:0] intensity_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_PLAY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_INTENSITY = 2'd0,
        REG_ENABLE    = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic     busy;
        pattern_t pat;
        step_t    step;
        ms_t      elapsed;
        duty_t    duty;
    } hps_state_t;

    // Cumulative end time of each step, in ms.
    localparam ms_t STEP_END [NUM_PATTERNS][MAX_STEPS] = '{
        '{8'd15, 8'd0,  8'd0,  8'd0,  8'd0 },
        '{8'd10, 8'd40, 8'd50, 8'd0,  8'd0 },
        '{8'd50, 8'd0,  8'd0,  8'd0,  8'd0 },
        '{8'd20, 8'd40, 8'd70, 8'd0,  8'd0 },
        '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50},
        '{8'd30, 8'd0,  8'd0,  8'd0,  8'd0 },
        '{8'd40, 8'd70, 8'd90, 8'd0,  8'd0 }
    };

    localparam step_t STEP_LEN [NUM_PATTERNS] = '{
        3'd1, 3'd3, 3'd1, 3'd3, 3'd5, 3'd1, 3'd3
    };

    // Bit i set: step i drives the motor.
    localparam logic [MAX_STEPS-1:0] STEP_ON [NUM_PATTERNS] = '{
        5'b00001, 5'b00101, 5'b00001, 5'b00101, 5'b10101, 5'b00001, 5'b00101
    };

    localparam intensity_t INTENSITY_MAX   = 7'd100;
    localparam duty_t      DUTY_RESET      = 8'd255;
    // duty = intensity*255/100 as (intensity * 255 * 5243) >> 19, exact for 0..100
    localparam logic [20:0] DUTY_RECIP     = 21'd1336965;
    localparam int          DUTY_SHIFT     = 19;

endpackage

/* hdl/hps_if.sv */
// Channel interfaces of the haptic pattern sequencer: command, result and
// configuration write. No dependencies.
`timescale 1ns / 1ps

interface hps_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] pattern;

    modport source (output valid, output op, output pattern, input ready);
    modport sink   (input valid, input op, input pattern, output ready);
endinterface

interface hps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic       playing;

    modport source (output valid, output duty, output playing, input ready);
    modport sink   (input valid, input duty, input playing, output ready);
endinterface

interface hps_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/hps_core.sv */
// Next-state logic of the sequencer: applies one command item to the state.
// Depends on hps_pkg.
`timescale 1ns / 1ps

module hps_core (
    input  hps_pkg::hps_state_t cur,
    input  logic                op,
    input  hps_pkg::pattern_t   pattern,
    input  logic                enable,
    input  hps_pkg::duty_t      on_duty,
    output hps_pkg::hps_state_t nxt
);
    import hps_pkg::*;

    ms_t   end_ms;
    ms_t   el_inc;
    step_t step_inc;
    logic  done;

    always_comb
    begin
        end_ms   = STEP_END[cur.pat][cur.step];
        el_inc   = (cur.elapsed == 8'd255) ? cur.elapsed : cur.elapsed + 8'd1;
        step_inc = cur.step + 3'd1;
        done     = (step_inc >= STEP_LEN[cur.pat]) || (step_inc >= 3'(MAX_STEPS));
        nxt      = cur;
        case (op_t'(op))
            OP_PLAY:
            begin
                if (enable && (pattern < 3'(NUM_PATTERNS)))
                begin
                    nxt.pat     = pattern;
                    nxt.step    = '0;
                    nxt.elapsed = '0;
                    nxt.busy    = 1'b1;
                    if (STEP_ON[pattern][0])
                        nxt.duty = on_duty;
                end
            end
            default:
            begin
                if (cur.busy)
                begin
                    nxt.elapsed = el_inc;
                    if (el_inc >= end_ms)
                    begin
                        nxt.step = step_inc;
                        if (done)
                        begin
                            nxt.duty = '0;
                            nxt.busy = 1'b0;
                        end
                        else if (STEP_ON[cur.pat][step_inc])
                            nxt.duty = on_duty;
                        else
                            nxt.duty = '0;
                    end
                end
            end
        endcase
    end

endmodule

/* hdl/haptic_pattern_sequencer_unit.sv */
// Haptic pattern sequencer top level: state, configuration and result register.
// Depends on hps_pkg, hps_if.sv interfaces and hps_core.
//
// Usage:
//   cmd    - command items: op 0 is a one millisecond tick, op 1 starts the
//            given pattern (ignored when disabled or pattern is 7).
//   result - one item per command: motor duty and the playing flag after
//            the command took effect.
//   cfg    - register writes: index 0 intensity (clamped to 100), index 1
//            enable. Always ready; write only while no item is in flight.
//   Latency: the result is valid the cycle after the command is accepted.
//   Throughput: one command per cycle while no result is held back; the
//   registered state update is the only loop.
//   A result register holds the pending item; cmd.ready stays high while the
//   result is empty or being taken, so a stalled receiver stalls commands
//   only while its item is still held.
//   Reset: idle, duty 0, intensity 100, enable 1, no result pending.
`timescale 1ns / 1ps

module haptic_pattern_sequencer_unit (
    input logic      clk,
    input logic      rst_n,
    hps_in_if.sink   cmd,
    hps_out_if.source result,
    hps_cfg_if.sink  cfg
);
    import hps_pkg::*;

    hps_state_t  state_reg;
    hps_state_t  state_next;
    duty_t       on_duty_reg;
    logic        enable_reg;
    logic        out_valid_reg;
    duty_t       out_duty_reg;
    logic        out_playing_reg;
    logic        cmd_accept;
    intensity_t  cfg_clamped;
    logic [27:0] cfg_product;

    assign cmd.ready  = !out_valid_reg || result.ready;
    assign cmd_accept = cmd.valid && cmd.ready;
    assign cfg.ready  = 1'b1;

    assign cfg_clamped = (cfg.data > INTENSITY_MAX) ? INTENSITY_MAX : cfg.data;
    assign cfg_product = 28'(cfg_clamped) * 28'(DUTY_RECIP);

    hps_core u_core (
        .cur     (state_reg),
        .op      (cmd.op),
        .pattern (cmd.pattern),
        .enable  (enable_reg),
        .on_duty (on_duty_reg),
        .nxt     (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            on_duty_reg   <= DUTY_RESET;
            enable_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
                state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_INTENSITY: on_duty_reg <= cfg_product[DUTY_SHIFT +: 8];
                    REG_ENABLE:    enable_reg  <= cfg.data[0];
                    default:       ;
                endcase
            end
            if (cmd_accept)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            out_duty_reg    <= state_next.duty;
            out_playing_reg <= state_next.busy;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.duty    = out_duty_reg;
    assign result.playing = out_playing_reg;

endmodule

/* hdl/hps_checker.sv */
// Port-level checker of the haptic pattern sequencer, bound to the top level.
// Depends on haptic_pattern_sequencer_unit_macros.svh.
`timescale 1ns / 1ps
`include "haptic_pattern_sequencer_unit_macros.svh"

module hps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] duty,
    input logic       playing
);

    // a held result stays and keeps its payload
    `HPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `HPS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(duty) && $stable(playing))
    // every new result comes from a command taken the cycle before
    `HPS_ASSERT_IMPL(a_no_invented, clk, rst_n, out_valid && !$past(out_valid && !out_ready), $past(in_valid && in_ready))
    // motor is off whenever no pattern plays
    `HPS_ASSERT_IMPL(a_idle_off, clk, rst_n, out_valid && !playing, duty == 8'd0)

endmodule

bind haptic_pattern_sequencer_unit hps_checker u_hps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .duty      (result.duty),
    .playing   (result.playing)
);
